// File: sv/lrf_pkg.sv
// shared types and constants for the line rasteriser frame unit
package lrf_pkg;

  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_DRAW  = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  localparam logic [7:0] LEVEL_RESET = 8'd255;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DRAW,
    ST_RD_ADDR,
    ST_RD_DATA
  } lrf_state_t;

  typedef enum logic [1:0] {
    SS_IDLE,
    SS_INIT,
    SS_DEC,
    SS_RUN
  } lrf_step_state_t;

endpackage

// File: sv/lrf_ram.sv
// generic simple dual port ram with registered read
module lrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/lrf_line_stepper.sv
// bresenham line stepper around one shared decision adder
module lrf_line_stepper #(
  parameter int FRAME_SIDE = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          go,
  input  logic signed [15:0]            start_row,
  input  logic signed [15:0]            end_row,
  output logic                          done,
  output logic                          px_we,
  output logic [$clog2(FRAME_SIDE)-1:0] px_col,
  output logic [$clog2(FRAME_SIDE)-1:0] px_row
);
  import lrf_pkg::*;

  localparam int CW = $clog2(FRAME_SIDE);
  localparam int MW = 17;
  localparam int DW = 20;
  localparam int RW = 18;
  localparam int XW = CW + 2;
  localparam logic [MW-1:0] SIDE_M1 = MW'(FRAME_SIDE - 1);

  lrf_step_state_t state_r, state_nxt;
  logic signed [15:0]   r0_r, r0_nxt, r1_r, r1_nxt;
  logic [MW-1:0]        major_r, major_nxt, minor_r, minor_nxt, cnt_r, cnt_nxt;
  logic                 rows_major_r, rows_major_nxt, rneg_r, rneg_nxt;
  logic                 plot_r, plot_nxt;
  logic signed [DW-1:0] dec_r, dec_nxt;
  logic signed [RW-1:0] row_r, row_nxt, row_step;
  logic [XW-1:0]        col_r, col_nxt;
  logic signed [DW-1:0] add_a, add_b, add_s;
  logic signed [MW-1:0] diff;
  logic [MW-1:0]        adiff;
  logic                 in_frame;

  assign diff  = MW'(r1_r) - MW'(r0_r);
  assign adiff = diff[MW-1] ? (~diff + 1'b1) : diff;

  // shared decision adder
  always_comb begin
    if (state_r == SS_DEC) begin
      add_a = $signed({2'b00, minor_r, 1'b0});
      add_b = -$signed({3'b000, major_r});
    end else begin
      add_a = dec_r;
      if (!dec_r[DW-1]) begin
        add_b = -$signed({2'b00, major_r, 1'b0});
      end else begin
        add_b = $signed({2'b00, minor_r, 1'b0});
      end
    end
  end
  assign add_s = add_a + add_b;

  assign row_step = rneg_r ? (row_r - RW'(1)) : (row_r + RW'(1));
  assign in_frame = !row_r[RW-1] && (row_r < $signed(RW'(FRAME_SIDE)))
                    && (col_r < XW'(FRAME_SIDE));

  assign px_col = col_r[CW-1:0];
  assign px_row = row_r[CW-1:0];

  always_comb begin
    state_nxt      = state_r;
    r0_nxt         = r0_r;
    r1_nxt         = r1_r;
    major_nxt      = major_r;
    minor_nxt      = minor_r;
    cnt_nxt        = cnt_r;
    rows_major_nxt = rows_major_r;
    rneg_nxt       = rneg_r;
    plot_nxt       = plot_r;
    dec_nxt        = dec_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    done           = 1'b0;
    px_we          = 1'b0;
    case (state_r)
      SS_IDLE: begin
        if (go) begin
          r0_nxt    = start_row;
          r1_nxt    = end_row;
          state_nxt = SS_INIT;
        end
      end
      SS_INIT: begin
        rneg_nxt = diff[MW-1];
        if (adiff > SIDE_M1) begin
          rows_major_nxt = 1'b1;
          major_nxt      = adiff;
          minor_nxt      = SIDE_M1;
        end else begin
          rows_major_nxt = 1'b0;
          major_nxt      = SIDE_M1;
          minor_nxt      = adiff;
        end
        row_nxt   = RW'(r0_r);
        col_nxt   = '0;
        cnt_nxt   = '0;
        plot_nxt  = 1'b1;
        state_nxt = SS_DEC;
      end
      SS_DEC: begin
        dec_nxt   = add_s;
        state_nxt = SS_RUN;
      end
      SS_RUN: begin
        px_we   = plot_r && in_frame;
        dec_nxt = add_s;
        if (!dec_r[DW-1]) begin
          // minor step
          plot_nxt = 1'b0;
          if (rows_major_r) begin
            col_nxt = col_r + XW'(1);
          end else begin
            row_nxt = row_step;
          end
        end else begin
          // major step
          plot_nxt = 1'b1;
          cnt_nxt  = cnt_r + MW'(1);
          if (rows_major_r) begin
            row_nxt = row_step;
          end else begin
            col_nxt = col_r + XW'(1);
          end
          if (cnt_nxt == major_r) begin
            done      = 1'b1;
            state_nxt = SS_IDLE;
          end
        end
      end
      default: state_nxt = SS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    r0_r         <= r0_nxt;
    r1_r         <= r1_nxt;
    major_r      <= major_nxt;
    minor_r      <= minor_nxt;
    cnt_r        <= cnt_nxt;
    rows_major_r <= rows_major_nxt;
    rneg_r       <= rneg_nxt;
    plot_r       <= plot_nxt;
    dec_r        <= dec_nxt;
    row_r        <= row_nxt;
    col_r        <= col_nxt;
  end

endmodule

// File: sv/line_rasterizer_frame_unit.sv
// top level: command sequencer, frame memory and line stepper
// read: the beat passes ST_RD_ADDR, then pixel_value strobes in ST_RD_DATA and the unit returns to idle
// draw: setup in SS_INIT and SS_DEC, then in SS_RUN each step is a major step (a plotted point) or a minor step,
//   as chosen by the single decision adder; busy stays high until the last major step
// clear: one frame word per cycle over all 2**(2*ceil(log2 FRAME_SIDE)) words (65536 at 256)
// reset: synchronous rst_n, draw_level back to 255, then the same clearing sweep with busy high
module line_rasterizer_frame_unit #(
  parameter int FRAME_SIDE = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_mode,
  input  logic signed [15:0] in_start_row,
  input  logic signed [15:0] in_end_row,
  input  logic [7:0]  in_read_col,
  input  logic [7:0]  in_read_row,
  output logic        out_valid,
  output logic [7:0]  out_pixel_value,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata
);
  import lrf_pkg::*;

  localparam int CW = $clog2(FRAME_SIDE);
  localparam int AW = 2 * CW;

  lrf_state_t    state_r, state_nxt;
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [7:0]    draw_level_r;
  logic [CW-1:0] rd_row_r, rd_row_nxt, rd_col_r, rd_col_nxt;
  logic          rd_ok_r, rd_ok_nxt;
  logic          accept, step_go, step_done, px_we;
  logic [CW-1:0] px_col, px_row;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata, ram_rdata;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  lrf_line_stepper #(
    .FRAME_SIDE(FRAME_SIDE)
  ) u_stepper (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (step_go),
    .start_row(in_start_row),
    .end_row  (in_end_row),
    .done     (step_done),
    .px_we    (px_we),
    .px_col   (px_col),
    .px_row   (px_row)
  );

  lrf_ram #(
    .WIDTH(8),
    .DEPTH(2 ** AW)
  ) u_frame (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr({rd_row_r, rd_col_r}),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_nxt       = state_r;
    clr_cnt_nxt     = clr_cnt_r;
    rd_row_nxt      = rd_row_r;
    rd_col_nxt      = rd_col_r;
    rd_ok_nxt       = rd_ok_r;
    step_go         = 1'b0;
    ram_we          = 1'b0;
    ram_waddr       = {px_row, px_col};
    ram_wdata       = draw_level_r;
    out_valid       = 1'b0;
    out_pixel_value = '0;
    case (state_r)
      ST_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        ram_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_mode)
            MODE_CLEAR: begin
              clr_cnt_nxt = '0;
              state_nxt   = ST_CLEAR;
            end
            MODE_DRAW: begin
              step_go   = 1'b1;
              state_nxt = ST_DRAW;
            end
            MODE_READ: begin
              rd_row_nxt = CW'(in_read_row);
              rd_col_nxt = CW'(in_read_col);
              rd_ok_nxt  = (32'(in_read_row) < FRAME_SIDE)
                           && (32'(in_read_col) < FRAME_SIDE);
              state_nxt  = ST_RD_ADDR;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_DRAW: begin
        ram_we = px_we;
        if (step_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RD_ADDR: begin
        state_nxt = ST_RD_DATA;
      end
      ST_RD_DATA: begin
        out_valid       = 1'b1;
        out_pixel_value = rd_ok_r ? ram_rdata : '0;
        state_nxt       = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_cnt_r    <= '0;
      draw_level_r <= LEVEL_RESET;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      if (cfg_we) begin
        draw_level_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_row_r <= rd_row_nxt;
    rd_col_r <= rd_col_nxt;
    rd_ok_r  <= rd_ok_nxt;
  end

endmodule

// File: sv/lrf_checker.sv
// port level checks for the line rasteriser frame unit, with bind
module lrf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic [1:0] in_mode,
  input logic       out_valid
);
  import lrf_pkg::*;

  logic accept;
  assign accept = start && !busy;

  // reset always starts a clearing sweep
  a_reset_sweep: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("no clearing sweep after reset");

  a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_mode == MODE_READ) |-> ##2 out_valid)
    else $error("read result not on time");

  a_no_stray_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_mode != MODE_READ) |=> !out_valid ##1 !out_valid)
    else $error("result beat without a read");

  a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result beat while idle");

  a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result longer than one beat");

endmodule

bind line_rasterizer_frame_unit lrf_checker u_lrf_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .start    (start),
  .busy     (busy),
  .in_mode  (in_mode),
  .out_valid(out_valid)
);

// File: tb/testbench.sv
// testbench for the line rasteriser frame unit: beat driver, result monitor and frame predictor
`timescale 1ns / 100ps

module testbench;
  import lrf_pkg::*;

  localparam int SIDE = 256;
  localparam logic [1:0] MODE_NONE = 2'd3;
  localparam int RAND_BEATS = 1830;
  localparam int SETTLE = 8;
  localparam int WATCH_LIMIT = 400000;

  typedef enum {BK_CMD, BK_CFG, BK_HOLD} beat_kind_e;

  typedef struct {
    beat_kind_e kind;
    logic [1:0] mode;
    logic signed [15:0] r0;
    logic signed [15:0] r1;
    logic [7:0] col;
    logic [7:0] row;
    logic [7:0] level;
    int unsigned gap;
  } cmd_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_mode = MODE_CLEAR;
  logic signed [15:0] in_start_row = '0;
  logic signed [15:0] in_end_row = '0;
  logic [7:0] in_read_col = '0;
  logic [7:0] in_read_row = '0;
  logic out_valid;
  logic [7:0] out_pixel_value;
  logic cfg_we = 1'b0;
  logic [7:0] cfg_wdata = '0;

  cmd_beat_t cmd_q[$];
  logic [7:0] pixel_due_q[$];
  logic [7:0] frame_img [SIDE*SIDE];
  logic [7:0] level_now = LEVEL_RESET;
  int unsigned gap_left = 0;
  int idle_run = 0;
  int errors = 0;
  int quiet_cycles = 0;

  always #10 clk = ~clk;

  line_rasterizer_frame_unit #(.FRAME_SIDE(SIDE)) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_mode(in_mode),
    .in_start_row(in_start_row),
    .in_end_row(in_end_row),
    .in_read_col(in_read_col),
    .in_read_row(in_read_row),
    .out_valid(out_valid),
    .out_pixel_value(out_pixel_value),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  function automatic void wipe_frame();
    for (int i = 0; i < SIDE*SIDE; i++) frame_img[i] = '0;
  endfunction

  function automatic void paint_line(longint r0, longint r1);
    longint major, minor, rstep, col, row, dec, t, i;
    bit rows_major;
    major = SIDE - 1;
    minor = (r1 > r0) ? r1 - r0 : r0 - r1;
    rstep = (r1 > r0) ? 1 : ((r1 < r0) ? -1 : 0);
    rows_major = 1'b0;
    if (minor > major) begin
      t = major;
      major = minor;
      minor = t;
      rows_major = 1'b1;
    end
    dec = 2 * minor - major;
    col = 0;
    row = r0;
    for (i = 1; i <= major; i++) begin
      if (col >= 0 && col < SIDE && row >= 0 && row < SIDE)
        frame_img[row * SIDE + col] = level_now;
      while (dec >= 0 && major > 0) begin
        dec -= 2 * major;
        if (rows_major) col += 1;
        else row += rstep;
      end
      dec += 2 * minor;
      if (rows_major) row += rstep;
      else col += 1;
    end
  endfunction

  function automatic logic signed [15:0] sat16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic int unsigned pick_gap(bit no_idle);
    int unsigned p;
    if (no_idle) return 0;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 98) return $urandom_range(4, 40);
    return $urandom_range(100, 400);
  endfunction

  task automatic push_cmd(logic [1:0] mode, longint r0, longint r1, int col, int row,
                          bit no_idle);
    cmd_beat_t b;
    b.kind = BK_CMD;
    b.mode = mode;
    b.r0 = sat16(r0);
    b.r1 = sat16(r1);
    b.col = col[7:0];
    b.row = row[7:0];
    b.level = '0;
    b.gap = pick_gap(no_idle);
    cmd_q.push_back(b);
  endtask

  task automatic push_cfg(logic [7:0] level);
    cmd_beat_t b;
    b = '{kind: BK_CFG, mode: MODE_NONE, r0: '0, r1: '0, col: '0, row: '0,
          level: level, gap: 0};
    cmd_q.push_back(b);
  endtask

  task automatic push_hold();
    cmd_beat_t b;
    b = '{kind: BK_HOLD, mode: MODE_NONE, r0: '0, r1: '0, col: '0, row: '0,
          level: '0, gap: 0};
    cmd_q.push_back(b);
  endtask

  // driver: inputs change on the falling edge, one assignment per signal per step
  always @(negedge clk) begin : drive_beats
    cmd_beat_t b;
    logic nx_start, nx_we;
    logic [1:0] nx_mode;
    logic [15:0] nx_r0, nx_r1;
    logic [7:0] nx_col, nx_row, nx_wdata;
    nx_start = 1'b0;
    nx_we = 1'b0;
    nx_mode = 2'($urandom);
    nx_r0 = 16'($urandom);
    nx_r1 = 16'($urandom);
    nx_col = 8'($urandom);
    nx_row = 8'($urandom);
    nx_wdata = 8'($urandom);
    if (rst_n) begin
      if (busy === 1'b0 && !start && !cfg_we) idle_run++;
      else idle_run = 0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (cmd_q.size() > 0) begin
        b = cmd_q[0];
        case (b.kind)
          BK_CMD: if (busy === 1'b0) begin
            nx_start = 1'b1;
            nx_mode = b.mode;
            nx_r0 = b.r0;
            nx_r1 = b.r1;
            nx_col = b.col;
            nx_row = b.row;
            gap_left = b.gap;
            void'(cmd_q.pop_front());
          end
          BK_CFG: if (idle_run >= SETTLE && pixel_due_q.size() == 0) begin
            nx_we = 1'b1;
            nx_wdata = b.level;
            level_now = b.level;
            void'(cmd_q.pop_front());
          end
          default: if (idle_run >= SETTLE && pixel_due_q.size() == 0) begin
            void'(cmd_q.pop_front());
          end
        endcase
      end
    end
    start <= nx_start;
    cfg_we <= nx_we;
    cfg_wdata <= nx_wdata;
    in_mode <= nx_mode;
    in_start_row <= nx_r0;
    in_end_row <= nx_r1;
    in_read_col <= nx_col;
    in_read_row <= nx_row;
  end

  // monitor: checks result beats, predicts on every accepted clear, draw or read beat
  always @(posedge clk) begin : watch_beats
    logic [7:0] want;
    bit moved;
    if (rst_n) begin
      moved = 1'b0;
      if (out_valid === 1'b1) begin
        moved = 1'b1;
        if (pixel_due_q.size() == 0) begin
          $error("pixel_value: unexpected result %0d", out_pixel_value);
          errors++;
        end else begin
          want = pixel_due_q.pop_front();
          if (out_pixel_value !== want) begin
            $error("pixel_value: expected %0d, got %0d", want, out_pixel_value);
            errors++;
          end
        end
      end
      if (start && busy === 1'b0) begin
        moved = 1'b1;
        case (in_mode)
          MODE_CLEAR: wipe_frame();
          MODE_DRAW:  paint_line(longint'(in_start_row), longint'(in_end_row));
          MODE_READ:  pixel_due_q.push_back(frame_img[int'(in_read_row) * SIDE + int'(in_read_col)]);
          default: ;
        endcase
      end
      if (moved) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCH_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin : run_test
    int rnd_count, n, p, q, phase, c, rr;
    longint r0, r1, last_r0, last_r1;
    bit no_idle;
    logic [7:0] lvl;
    wipe_frame();

    // directed part
    push_cfg(8'ha5);
    push_cmd(MODE_READ, 0, 0, 0, 0, 0);
    push_cmd(MODE_READ, 0, 0, 255, 255, 0);
    push_cmd(MODE_DRAW, 0, 0, 0, 0, 0);
    push_cmd(MODE_READ, 0, 0, 0, 0, 0);
    push_cmd(MODE_READ, 0, 0, 254, 0, 0);
    push_cmd(MODE_READ, 0, 0, 255, 0, 0);
    push_cmd(MODE_DRAW, 255, 0, 0, 0, 0);
    push_cmd(MODE_READ, 0, 0, 100, 155, 0);
    push_cmd(MODE_DRAW, -32768, 32767, 0, 0, 0);
    push_cmd(MODE_READ, 0, 0, 0, 255, 0);
    push_cmd(MODE_DRAW, 32767, 32767, 0, 0, 0);
    push_cmd(MODE_DRAW, -32768, -32768, 0, 0, 0);
    push_cmd(MODE_DRAW, 10, 600, 0, 0, 0);
    push_cmd(MODE_READ, 0, 0, 100, 241, 0);
    push_cmd(MODE_NONE, 0, 0, 0, 0, 0);
    push_cfg(8'h00);
    push_cmd(MODE_DRAW, 0, 0, 0, 0, 0);
    push_cmd(MODE_READ, 0, 0, 5, 0, 0);
    push_hold();
    push_cfg(8'hff);
    push_cmd(MODE_CLEAR, 0, 0, 0, 0, 0);
    push_cmd(MODE_READ, 0, 0, 0, 0, 0);
    push_cmd(MODE_READ, 0, 0, 100, 155, 0);

    // random phases: level write, then draws mixed with reads, some aimed at the drawn lines
    rnd_count = 0;
    phase = 0;
    last_r0 = 0;
    last_r1 = 0;
    while (rnd_count < RAND_BEATS) begin
      no_idle = ($urandom_range(0, 3) == 0);
      case (phase % 5)
        0: lvl = 8'h00;
        1: lvl = 8'hff;
        default: lvl = 8'($urandom);
      endcase
      push_cfg(lvl);
      if ($urandom_range(0, 9) == 0) push_cmd(MODE_CLEAR, 0, 0, 0, 0, no_idle);
      n = $urandom_range(30, 80);
      for (int k = 0; k < n; k++) begin
        p = $urandom_range(0, 99);
        if (p < 28) begin
          q = $urandom_range(0, 99);
          if (q < 70) begin
            r0 = longint'($urandom_range(0, 295)) - 20;
            r1 = longint'($urandom_range(0, 295)) - 20;
          end else if (q < 88) begin
            r0 = $urandom_range(0, 255);
            r1 = longint'($urandom_range(256, 900));
            if ($urandom_range(0, 1)) r1 = -r1;
            r1 = r0 + r1;
          end else begin
            r0 = longint'($signed(16'($urandom)));
            r1 = r0 + longint'($urandom_range(0, 600)) - 300;
          end
          last_r0 = longint'(sat16(r0));
          last_r1 = longint'(sat16(r1));
          push_cmd(MODE_DRAW, r0, r1, 0, 0, no_idle);
        end else if (p < 60) begin
          c = $urandom_range(0, 254);
          rr = int'(last_r0 + ((last_r1 - last_r0) * c) / 255) + $urandom_range(0, 2) - 1;
          if (rr < 0 || rr > 255) rr = $urandom_range(0, 255);
          push_cmd(MODE_READ, 0, 0, c, rr, no_idle);
        end else if (p < 96) begin
          push_cmd(MODE_READ, 0, 0, $urandom_range(0, 255), $urandom_range(0, 255), no_idle);
        end else begin
          push_cmd(MODE_NONE, $signed(16'($urandom)), $signed(16'($urandom)),
                   $urandom_range(0, 255), $urandom_range(0, 255), no_idle);
        end
        rnd_count++;
      end
      if ($urandom_range(0, 2) == 0) push_hold();
      phase++;
    end

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    while (cmd_q.size() != 0 || idle_run < SETTLE) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (pixel_due_q.size() != 0) begin
      $error("pixel_value: %0d results never arrived", pixel_due_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/lrf_pkg.sv
sv/lrf_ram.sv
sv/lrf_line_stepper.sv
sv/line_rasterizer_frame_unit.sv
sv/lrf_checker.sv
tb/testbench.sv
